[sv/rcdm_pkg.sv]
// ----------------------------------------------------------------------------
// rcdm_pkg
// Types, constants and microcode for the RC differential-drive mixer.
// ----------------------------------------------------------------------------
package rcdm_pkg;

    localparam int KICK_TIME_MS  = 40;
    localparam int DUTY_MAX      = 1023;
    localparam int PULSE_MAX_US  = 20000;
    localparam int LOST_BELOW_US = 100;
    localparam int SCALE_SPAN    = 255;
    localparam int SCALE_X2      = 2 * SCALE_SPAN;

    // duty saturates at DUTY_MAX and at the 10-bit field width
    localparam logic [9:0] DUTY_LIM = 10'((DUTY_MAX > 1023) ? 1023 : DUTY_MAX);

    // |x - lo| * 510 stays below 2^24, so 24 quotient bits cover every case
    localparam int DIV_STEPS = 24;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // configuration register indexes
    localparam logic [2:0] CFG_THR_MIN  = 3'd0;
    localparam logic [2:0] CFG_THR_MAX  = 3'd1;
    localparam logic [2:0] CFG_STR_MIN  = 3'd2;
    localparam logic [2:0] CFG_STR_MAX  = 3'd3;
    localparam logic [2:0] CFG_KICK_EN  = 3'd4;
    localparam logic [2:0] CFG_KICK_LVL = 3'd5;
    localparam logic [2:0] CFG_KICK_ON  = 3'd6;
    localparam logic [2:0] CFG_KICK_OFF = 3'd7;

    typedef struct packed {
        logic [14:0] steer_pulse_us;
        logic [14:0] throttle_pulse_us;
        logic [31:0] now_ms;
    } t_in;

    typedef struct packed {
        logic       right_forward;
        logic [9:0] right_duty;
        logic       left_forward;
        logic [9:0] left_duty;
    } t_out;

    typedef struct packed {
        logic [14:0] thr_min;
        logic [14:0] thr_max;
        logic [14:0] str_min;
        logic [14:0] str_max;
        logic        kick_en;
        logic [9:0]  kick_lvl;
        logic [9:0]  kick_on;
        logic [9:0]  kick_off;
    } t_cfg;

    typedef struct packed {
        logic       r_fwd;
        logic [9:0] r_mag;
        logic       l_fwd;
        logic [9:0] l_mag;
    } t_mix;

    typedef enum logic [2:0] {
        OP_IDLE = 3'd0,
        OP_LOAD = 3'd1,
        OP_DIV  = 3'd2,
        OP_FIN  = 3'd3,
        OP_MIX  = 3'd4,
        OP_NOP  = 3'd5,
        OP_PUT  = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER    = 3'd0,
        C_ALWAYS   = 3'd1,
        C_NO_IN    = 3'd2,
        C_CNT_NZ   = 3'd3,
        C_OUT_FULL = 3'd4
    } t_cond;

    localparam logic AX_THR = 1'b0;
    localparam logic AX_STR = 1'b1;

    typedef logic [3:0] t_pc;

    typedef struct packed {
        t_op   op;
        logic  axis;
        t_cond cond;
        t_pc   target;
    } t_uop;

    typedef struct packed {
        t_op  op;
        logic axis;
    } t_ctrl;

    typedef struct packed {
        logic in_acc;
        logic out_full;
    } t_stat;

    // control store
    function automatic t_uop ucode(input t_pc pc);
        t_uop u;
        case (pc)
            4'd0:    u = '{OP_IDLE, AX_THR, C_NO_IN,    4'd0};
            4'd1:    u = '{OP_LOAD, AX_THR, C_NEVER,    4'd0};
            4'd2:    u = '{OP_DIV,  AX_THR, C_CNT_NZ,   4'd2};
            4'd3:    u = '{OP_FIN,  AX_THR, C_NEVER,    4'd0};
            4'd4:    u = '{OP_LOAD, AX_STR, C_NEVER,    4'd0};
            4'd5:    u = '{OP_DIV,  AX_STR, C_CNT_NZ,   4'd5};
            4'd6:    u = '{OP_FIN,  AX_STR, C_NEVER,    4'd0};
            4'd7:    u = '{OP_MIX,  AX_THR, C_NEVER,    4'd0};
            4'd8:    u = '{OP_NOP,  AX_THR, C_OUT_FULL, 4'd8};
            4'd9:    u = '{OP_PUT,  AX_THR, C_ALWAYS,   4'd0};
            default: u = '{OP_NOP,  AX_THR, C_ALWAYS,   4'd0};
        endcase
        return u;
    endfunction

endpackage

[sv/rcdm_seq.sv]
// ----------------------------------------------------------------------------
// rcdm_seq
// Microcode sequencer: step counter, loop counter and conditional jumps.
// ----------------------------------------------------------------------------
module rcdm_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rcdm_pkg::t_stat i_stat,
    output rcdm_pkg::t_ctrl o_ctrl
);
    import rcdm_pkg::*;

    t_pc              r_pc, n_pc;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_uop             w_uop;
    logic             w_take;

    assign w_uop = ucode(r_pc);

    always_comb begin
        unique case (w_uop.cond)
            C_NEVER:    w_take = 1'b0;
            C_ALWAYS:   w_take = 1'b1;
            C_NO_IN:    w_take = !i_stat.in_acc;
            C_CNT_NZ:   w_take = (r_cnt != '0);
            C_OUT_FULL: w_take = i_stat.out_full;
            default:    w_take = 1'b0;
        endcase
        n_pc = w_take ? w_uop.target : t_pc'(r_pc + 4'd1);
    end

    always_comb begin
        n_cnt = r_cnt;
        if (w_uop.op == OP_LOAD) begin
            n_cnt = CNT_W'(DIV_STEPS - 1);
        end else if (w_uop.op == OP_DIV && r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= '0;
            r_cnt <= '0;
        end else begin
            r_pc  <= n_pc;
            r_cnt <= n_cnt;
        end
    end

    assign o_ctrl.op   = w_uop.op;
    assign o_ctrl.axis = w_uop.axis;

endmodule

[sv/rcdm_dpath.sv]
// ----------------------------------------------------------------------------
// rcdm_dpath
// Pulse scaling datapath: lost-pulse fill, shift-subtract divider, mixing.
// ----------------------------------------------------------------------------
module rcdm_dpath (
    input  logic            i_clk,
    input  logic            i_in_acc,
    input  rcdm_pkg::t_in   i_in,
    input  rcdm_pkg::t_cfg  i_cfg,
    input  rcdm_pkg::t_ctrl i_ctrl,
    output rcdm_pkg::t_mix  o_mix,
    output logic [31:0]     o_now
);
    import rcdm_pkg::*;

    t_in                r_in;
    logic [23:0]        r_num;
    logic [14:0]        r_den;
    logic [14:0]        r_rem;
    logic               r_neg;
    logic               r_deg;
    logic signed [25:0] r_t, r_s;
    t_mix               r_mix;

    // operand setup for the selected axis
    logic [14:0]        w_pulse, w_lo, w_hi;
    logic signed [15:0] w_d, w_half;
    logic signed [16:0] w_x, w_diff;
    logic [15:0]        w_adiff;
    logic [14:0]        w_ad;
    logic [23:0]        w_prod;
    logic               w_lost;

    always_comb begin
        w_pulse = (i_ctrl.axis == AX_STR) ? r_in.steer_pulse_us : r_in.throttle_pulse_us;
        w_lo    = (i_ctrl.axis == AX_STR) ? i_cfg.str_min : i_cfg.thr_min;
        w_hi    = (i_ctrl.axis == AX_STR) ? i_cfg.str_max : i_cfg.thr_max;
        w_d     = $signed({1'b0, w_hi}) - $signed({1'b0, w_lo});
        // halve toward zero
        w_half  = (w_d + $signed({15'd0, w_d[15]})) >>> 1;
        w_lost  = (w_pulse < 15'(LOST_BELOW_US)) || ({1'b0, w_pulse} > 16'(PULSE_MAX_US));
        w_x     = w_lost ? ($signed({2'b0, w_lo}) + 17'(w_half)) : $signed({2'b0, w_pulse});
        w_diff  = w_x - $signed({2'b0, w_lo});
        w_adiff = w_diff[16] ? 16'(-w_diff) : w_diff[15:0];
        w_ad    = w_d[15] ? 15'(-w_d) : w_d[14:0];
        w_prod  = 24'(w_adiff) * 24'(SCALE_X2);
    end

    // one restoring division step
    logic [15:0] w_trial;
    logic        w_ge;
    assign w_trial = {r_rem, r_num[23]};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    // signed quotient less the span
    logic signed [24:0] w_q;
    logic signed [25:0] w_val;
    assign w_q   = r_neg ? -$signed({1'b0, r_num}) : $signed({1'b0, r_num});
    assign w_val = r_deg ? -26'sd255 : (26'(w_q) - 26'(SCALE_SPAN));

    // mix and saturate
    logic signed [26:0] w_right, w_left;
    logic [25:0]        w_rmag, w_lmag;
    assign w_right = 27'(r_t) - 27'(r_s);
    assign w_left  = 27'(r_t) + 27'(r_s);
    assign w_rmag  = w_right[26] ? 26'(-w_right) : w_right[25:0];
    assign w_lmag  = w_left[26]  ? 26'(-w_left)  : w_left[25:0];

    always_ff @(posedge i_clk) begin
        if (i_in_acc) begin
            r_in <= i_in;
        end
        case (i_ctrl.op)
            OP_LOAD: begin
                r_num <= w_prod;
                r_den <= w_ad;
                r_rem <= '0;
                r_neg <= w_diff[16] ^ w_d[15];
                r_deg <= (w_d == '0);
            end
            OP_DIV: begin
                r_rem <= w_ge ? 15'(w_trial - {1'b0, r_den}) : w_trial[14:0];
                r_num <= {r_num[22:0], w_ge};
            end
            OP_FIN: begin
                if (i_ctrl.axis == AX_STR) begin
                    r_s <= w_val;
                end else begin
                    r_t <= w_val;
                end
            end
            OP_MIX: begin
                r_mix.r_fwd <= !w_right[26];
                r_mix.l_fwd <= !w_left[26];
                r_mix.r_mag <= (w_rmag > 26'(DUTY_LIM)) ? DUTY_LIM : w_rmag[9:0];
                r_mix.l_mag <= (w_lmag > 26'(DUTY_LIM)) ? DUTY_LIM : w_lmag[9:0];
            end
            default: ;
        endcase
    end

    assign o_mix = r_mix;
    assign o_now = r_in.now_ms;

endmodule

[sv/rcdm_kick.sv]
// ----------------------------------------------------------------------------
// rcdm_kick
// Per-motor kickstart: latch, start time and held duty.
// ----------------------------------------------------------------------------
module rcdm_kick (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_upd,
    input  logic [9:0]     i_mag,
    input  logic [31:0]    i_now,
    input  rcdm_pkg::t_cfg i_cfg,
    output logic [9:0]     o_duty_next
);
    import rcdm_pkg::*;

    logic        r_active, n_active;
    logic [31:0] r_start, n_start;
    logic [9:0]  r_held, n_held;

    always_comb begin
        n_active = r_active;
        n_start  = r_start;
        n_held   = r_held;
        if (!r_active && i_mag >= i_cfg.kick_on && i_cfg.kick_en) begin
            n_held   = i_cfg.kick_lvl;
            n_start  = i_now;
            n_active = 1'b1;
        end
        // also checked with no kick latched, against the last start time
        if ((i_now - n_start) > 32'(KICK_TIME_MS)) begin
            n_held = i_mag;
        end
        if (n_active && i_mag <= i_cfg.kick_off) begin
            n_active = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_start  <= '0;
            r_held   <= '0;
        end else if (i_upd) begin
            r_active <= n_active;
            r_start  <= n_start;
            r_held   <= n_held;
        end
    end

    assign o_duty_next = n_held;

endmodule

[sv/rc_differential_drive_mixer.sv]
// ----------------------------------------------------------------------------
// rc_differential_drive_mixer
// Each input transaction runs through load, two 24-step shift-subtract divisions
// in the shared datapath, mix and output write; the write waits while the output
// register is full, and the input stalls until the sequencer is back in idle.
// Reset (synchronous, active low) restores the register defaults and clears
// kick state, held duties and output valid.
// ----------------------------------------------------------------------------
module rc_differential_drive_mixer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  rcdm_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output rcdm_pkg::t_out o_out_data,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_idx,
    input  logic [14:0]    i_cfg_data
);
    import rcdm_pkg::*;

    t_cfg  r_cfg;
    t_ctrl w_ctrl;
    t_stat w_stat;
    t_mix  w_mix;
    logic [31:0] w_now;
    logic [9:0]  w_rduty, w_lduty;
    logic        w_in_acc, w_put;
    logic        r_out_valid;
    t_out        r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thr_min  <= 15'd1088;
            r_cfg.thr_max  <= 15'd1924;
            r_cfg.str_min  <= 15'd1088;
            r_cfg.str_max  <= 15'd1924;
            r_cfg.kick_en  <= 1'b1;
            r_cfg.kick_lvl <= 10'd150;
            r_cfg.kick_on  <= 10'd60;
            r_cfg.kick_off <= 10'd50;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_THR_MIN:  r_cfg.thr_min  <= i_cfg_data;
                CFG_THR_MAX:  r_cfg.thr_max  <= i_cfg_data;
                CFG_STR_MIN:  r_cfg.str_min  <= i_cfg_data;
                CFG_STR_MAX:  r_cfg.str_max  <= i_cfg_data;
                CFG_KICK_EN:  r_cfg.kick_en  <= i_cfg_data[0];
                CFG_KICK_LVL: r_cfg.kick_lvl <= i_cfg_data[9:0];
                CFG_KICK_ON:  r_cfg.kick_on  <= i_cfg_data[9:0];
                CFG_KICK_OFF: r_cfg.kick_off <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    assign o_in_stall      = (w_ctrl.op != OP_IDLE);
    assign w_in_acc        = i_in_valid && !o_in_stall;
    assign w_put           = (w_ctrl.op == OP_PUT);
    assign w_stat.in_acc   = w_in_acc;
    assign w_stat.out_full = r_out_valid && i_out_stall;

    rcdm_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    rcdm_dpath u_dpath (
        .i_clk    (i_clk),
        .i_in_acc (w_in_acc),
        .i_in     (i_in_data),
        .i_cfg    (r_cfg),
        .i_ctrl   (w_ctrl),
        .o_mix    (w_mix),
        .o_now    (w_now)
    );

    rcdm_kick u_kick_r (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_upd       (w_put),
        .i_mag       (w_mix.r_mag),
        .i_now       (w_now),
        .i_cfg       (r_cfg),
        .o_duty_next (w_rduty)
    );

    rcdm_kick u_kick_l (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_upd       (w_put),
        .i_mag       (w_mix.l_mag),
        .i_now       (w_now),
        .i_cfg       (r_cfg),
        .o_duty_next (w_lduty)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_put) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_put) begin
            r_out.right_forward <= w_mix.r_fwd;
            r_out.right_duty    <= w_rduty;
            r_out.left_forward  <= w_mix.l_fwd;
            r_out.left_duty     <= w_lduty;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // an accepted transaction takes the sequencer out of idle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_in_stall)
        else $error("input not stalled after accept");

    // the result is written only into a free output register
    a_put_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_put |-> !r_out_valid)
        else $error("output overwritten");

    // output valid rises only from a write step
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_put))
        else $error("output valid without result");

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RC differential-drive mixer. A queue-fed driver
// offers pulse/timestamp transactions, an internal predictor computes the
// expected direction and duty of both motors (map, mix, saturate, kickstart),
// and a monitor checks every output transaction in order. Runs directed
// corner cases, then random stick walks and noise under several register
// settings, with random idling on both sides, a long output hold-off and a
// sender pause.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rcdm_pkg::*;

    typedef struct packed {
        logic        active;
        logic [31:0] start_ms;
        logic [9:0]  held;
    } t_motor;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    t_in         in_data     = '0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    t_out        out_data;
    logic        cfg_we      = 1'b0;
    logic [2:0]  cfg_idx     = CFG_THR_MIN;
    logic [14:0] cfg_data    = '0;

    logic        quiet        = 1'b0;
    logic        sender_hold  = 1'b0;
    logic        long_hold_go = 1'b0;

    t_in         pulse_q[$];
    t_out        mix_expect_q[$];
    t_cfg        cfg_m;
    t_motor      mot_r;
    t_motor      mot_l;

    int          gap_cnt    = 0;
    int          stall_cnt  = 0;
    int          hold_cnt   = 0;
    int          n_in       = 0;
    int          n_out      = 0;
    int          n_err      = 0;
    int          n_shown    = 0;
    int          n_settings = 1;
    logic [31:0] now_cursor = 32'd1000;
    int          thr_walk   = 1506;
    int          str_walk   = 1506;

    rc_differential_drive_mixer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic longint axis_scale(input logic [14:0] pulse,
                                          input logic [14:0] lo_u,
                                          input logic [14:0] hi_u);
        longint lo;
        longint hi;
        longint x;
        lo = lo_u;
        hi = hi_u;
        x  = pulse;
        // lost or timed-out pulse falls back to the calibration midpoint
        if (x < LOST_BELOW_US || x > PULSE_MAX_US)
            x = lo + (hi - lo) / 2;
        if (hi == lo)
            return -SCALE_SPAN;
        return (x - lo) * SCALE_X2 / (hi - lo) - SCALE_SPAN;
    endfunction

    function automatic logic [9:0] duty_limit(input longint mix);
        longint m;
        m = (mix < 0) ? -mix : mix;
        if (m > DUTY_MAX)
            m = DUTY_MAX;
        if (m > 1023)
            m = 1023;
        return 10'(m);
    endfunction

    function automatic t_motor kick_service(input t_motor m, input logic [9:0] mag,
                                            input logic [31:0] now);
        logic [31:0] elapsed;
        if (!m.active && mag >= cfg_m.kick_on && cfg_m.kick_en) begin
            m.held     = cfg_m.kick_lvl;
            m.start_ms = now;
            m.active   = 1'b1;
        end
        // window test also runs on a stale start time
        elapsed = now - m.start_ms;
        if (elapsed > 32'(KICK_TIME_MS))
            m.held = mag;
        if (m.active && mag <= cfg_m.kick_off)
            m.active = 1'b0;
        return m;
    endfunction

    task automatic predict_mix(input t_in it);
        longint thr_s;
        longint str_s;
        longint right_m;
        longint left_m;
        t_out   e;
        thr_s   = axis_scale(it.throttle_pulse_us, cfg_m.thr_min, cfg_m.thr_max);
        str_s   = axis_scale(it.steer_pulse_us, cfg_m.str_min, cfg_m.str_max);
        right_m = thr_s - str_s;
        left_m  = thr_s + str_s;
        mot_r   = kick_service(mot_r, duty_limit(right_m), it.now_ms);
        mot_l   = kick_service(mot_l, duty_limit(left_m), it.now_ms);
        e.right_forward = (right_m >= 0);
        e.right_duty    = mot_r.held;
        e.left_forward  = (left_m >= 0);
        e.left_duty     = mot_l.held;
        mix_expect_q.push_back(e);
    endtask

    // ------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (in_valid) begin
                predict_mix(in_data);
                void'(pulse_q.pop_front());
                n_in++;
                if (!quiet && $urandom_range(0, 3) == 0)
                    gap_cnt = $urandom_range(1, 8);
            end
            if (gap_cnt > 0) begin
                gap_cnt--;
                in_valid <= 1'b0;
            end else if (pulse_q.size() != 0 && !sender_hold) begin
                in_valid <= 1'b1;
                in_data  <= pulse_q[0];
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor and receiver stall
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && out_valid && !out_stall) begin
            n_out++;
            if (mix_expect_q.size() == 0) begin
                n_err++;
                if (n_shown < 10) begin
                    n_shown++;
                    $display("%0t: unexpected output R %0b/%0d L %0b/%0d",
                             $realtime, out_data.right_forward, out_data.right_duty,
                             out_data.left_forward, out_data.left_duty);
                end
            end else begin
                e = mix_expect_q.pop_front();
                if (out_data.right_forward !== e.right_forward ||
                    out_data.right_duty !== e.right_duty ||
                    out_data.left_forward !== e.left_forward ||
                    out_data.left_duty !== e.left_duty) begin
                    n_err++;
                    if (n_shown < 10) begin
                        n_shown++;
                        $display("%0t: got R %0b/%0d L %0b/%0d, expected R %0b/%0d L %0b/%0d",
                                 $realtime, out_data.right_forward, out_data.right_duty,
                                 out_data.left_forward, out_data.left_duty,
                                 e.right_forward, e.right_duty, e.left_forward, e.left_duty);
                    end
                end
            end
        end
        if (long_hold_go)
            hold_cnt = 600;
        if (hold_cnt > 0) begin
            hold_cnt--;
            out_stall <= 1'b1;
        end else if (stall_cnt > 0) begin
            stall_cnt--;
            out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_cnt = $urandom_range(1, 8) - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic cfg_write(input logic [2:0] idx, input logic [14:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            CFG_THR_MIN:  cfg_m.thr_min  = val;
            CFG_THR_MAX:  cfg_m.thr_max  = val;
            CFG_STR_MIN:  cfg_m.str_min  = val;
            CFG_STR_MAX:  cfg_m.str_max  = val;
            CFG_KICK_EN:  cfg_m.kick_en  = val[0];
            CFG_KICK_LVL: cfg_m.kick_lvl = val[9:0];
            CFG_KICK_ON:  cfg_m.kick_on  = val[9:0];
            CFG_KICK_OFF: cfg_m.kick_off = val[9:0];
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(input logic [14:0] thr_lo, input logic [14:0] thr_hi,
                                 input logic [14:0] str_lo, input logic [14:0] str_hi,
                                 input logic [14:0] ken, input logic [14:0] lvl,
                                 input logic [14:0] on_th, input logic [14:0] off_th);
        cfg_write(CFG_THR_MIN, thr_lo);
        cfg_write(CFG_THR_MAX, thr_hi);
        cfg_write(CFG_STR_MIN, str_lo);
        cfg_write(CFG_STR_MAX, str_hi);
        cfg_write(CFG_KICK_EN, ken);
        cfg_write(CFG_KICK_LVL, lvl);
        cfg_write(CFG_KICK_ON, on_th);
        cfg_write(CFG_KICK_OFF, off_th);
        n_settings++;
    endtask

    function automatic logic [14:0] rand_cal(input int lo, input int hi);
        if ($urandom_range(0, 3) == 0)
            return 15'($urandom_range(0, 32767));
        return 15'($urandom_range(lo, hi));
    endfunction

    task automatic random_setting();
        logic [14:0] on_th;
        on_th = 15'($urandom_range(0, 300));
        apply_setting(rand_cal(900, 1300), rand_cal(1700, 2200),
                      rand_cal(900, 1300), rand_cal(1700, 2200),
                      15'($urandom_range(0, 1)), 15'($urandom_range(0, 32767)),
                      on_th, 15'($urandom_range(0, on_th + 20)));
    endtask

    function automatic t_in pulse_item(input int steer, input int thr, input logic [31:0] now);
        t_in it;
        it.steer_pulse_us    = 15'(steer);
        it.throttle_pulse_us = 15'(thr);
        it.now_ms            = now;
        return it;
    endfunction

    // stick walk mostly, with lost-pulse values and raw noise mixed in
    function automatic logic [14:0] pick_pulse(inout int walk);
        int sel;
        sel  = $urandom_range(0, 99);
        walk = walk + int'($urandom_range(0, 120)) - 60;
        if (walk < 900)
            walk = 900;
        if (walk > 2100)
            walk = 2100;
        if (sel < 78)
            return 15'(walk);
        if (sel < 90) begin
            case ($urandom_range(0, 5))
                0:       return 15'd0;
                1:       return 15'(LOST_BELOW_US - 1);
                2:       return 15'(LOST_BELOW_US);
                3:       return 15'(PULSE_MAX_US);
                4:       return 15'(PULSE_MAX_US + 1);
                default: return 15'h7FFF;
            endcase
        end
        return 15'($urandom_range(0, 32767));
    endfunction

    function automatic t_in next_item();
        t_in it;
        int  pick;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            now_cursor = $urandom;
        else if (pick < 7)
            now_cursor = 32'hFFFF_FFFF - $urandom_range(0, 60);
        else
            now_cursor = now_cursor + $urandom_range(0, 30);
        it.now_ms            = now_cursor;
        it.throttle_pulse_us = pick_pulse(thr_walk);
        it.steer_pulse_us    = pick_pulse(str_walk);
        return it;
    endfunction

    task automatic drain();
        while (pulse_q.size() != 0 || mix_expect_q.size() != 0 || in_valid)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic run_phase(input int count);
        repeat (count) pulse_q.push_back(next_item());
        drain();
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        cfg_m.thr_min  = 15'd1088;
        cfg_m.thr_max  = 15'd1924;
        cfg_m.str_min  = 15'd1088;
        cfg_m.str_max  = 15'd1924;
        cfg_m.kick_en  = 1'b1;
        cfg_m.kick_lvl = 10'd150;
        cfg_m.kick_on  = 10'd60;
        cfg_m.kick_off = 10'd50;
        mot_r = '0;
        mot_l = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: stale start after reset, kick window, mix extremes,
        // lost pulses on both sides of the limits, timestamp wrap
        pulse_q.push_back(pulse_item(1506, 1506, 32'd10));
        pulse_q.push_back(pulse_item(1506, 1924, 32'd20));
        pulse_q.push_back(pulse_item(1506, 1924, 32'd50));
        pulse_q.push_back(pulse_item(1506, 1924, 32'd61));
        pulse_q.push_back(pulse_item(1506, 1088, 32'd70));
        pulse_q.push_back(pulse_item(1924, 1506, 32'd80));
        pulse_q.push_back(pulse_item(1088, 1506, 32'd90));
        pulse_q.push_back(pulse_item(1924, 1924, 32'd100));
        pulse_q.push_back(pulse_item(1088, 1924, 32'd110));
        pulse_q.push_back(pulse_item(0, 0, 32'd200));
        pulse_q.push_back(pulse_item(100, 99, 32'd300));
        pulse_q.push_back(pulse_item(20001, 20000, 32'd301));
        pulse_q.push_back(pulse_item(32767, 32767, 32'd400));
        pulse_q.push_back(pulse_item(1506, 1506, 32'd500));
        pulse_q.push_back(pulse_item(1506, 1700, 32'hFFFF_FFF0));
        pulse_q.push_back(pulse_item(1506, 1700, 32'h0000_0010));
        pulse_q.push_back(pulse_item(1506, 1700, 32'h0000_0020));
        pulse_q.push_back(pulse_item(1506, 1506, 32'hFFFF_FFFF));
        pulse_q.push_back(pulse_item(99, 100, 32'h7FFF_FFFF));
        drain();

        run_phase(300);

        // flat throttle calibration, reversed steering, kickstart off
        apply_setting(15'd1500, 15'd1500, 15'd1924, 15'd1088,
                      15'd0, 15'd200, 15'd100, 15'd20);
        run_phase(150);

        // widest spans, all data bits set, kick on every transaction
        apply_setting(15'd0, 15'h7FFF, 15'h7FFF, 15'd0,
                      15'h7FFF, 15'h7FFF, 15'd0, 15'h7FFF);
        run_phase(120);

        // kick at zero level, on threshold at full duty
        apply_setting(15'd1000, 15'd2000, 15'd1000, 15'd2000,
                      15'd1, 15'd0, 15'd1023, 15'd0);
        run_phase(120);

        // backpressure: long output hold-off while the sender keeps offering,
        // then a sender pause until all results are in
        apply_setting(15'd1088, 15'd1924, 15'd1088, 15'd1924,
                      15'd1, 15'd150, 15'd60, 15'd50);
        repeat (40) pulse_q.push_back(next_item());
        @(posedge i_clk);
        long_hold_go <= 1'b1;
        @(posedge i_clk);
        long_hold_go <= 1'b0;
        while (pulse_q.size() > 20)
            @(posedge i_clk);
        sender_hold <= 1'b1;
        @(posedge i_clk);
        while (mix_expect_q.size() != 0 || in_valid)
            @(posedge i_clk);
        sender_hold <= 1'b0;
        drain();

        repeat (4) begin
            random_setting();
            run_phase(150);
        end

        // closing stretch at full rate
        quiet <= 1'b1;
        apply_setting(15'd1088, 15'd1924, 15'd1088, 15'd1924,
                      15'd1, 15'd150, 15'd60, 15'd50);
        run_phase(300);

        repeat (80) @(posedge i_clk);
        $display("Run covered %0d input and %0d output transactions, %0d register sets,",
                 n_in, n_out, n_settings);
        $display("with stall bursts, a long output hold-off and a sender pause; %0d errors.",
                 n_err);
        if (n_err == 0 && mix_expect_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("timeout with %0d results outstanding", mix_expect_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
